// ===== src/pbsp_pkg.sv =====
// Package with shared types, constants and codes for the periodic block shortest path core.
package pbsp_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int MAX_EDGES  = 4096;
  localparam int MAX_PERIOD = 64;

  localparam int NODE_W     = 10;
  localparam int NODE_CNT_W = 11;
  localparam int EDGE_AW    = 12;
  localparam int EDGE_CNT_W = 13;
  localparam int SLOT_W     = 6;
  localparam int PER_W      = 7;
  localparam int MASK_W     = 64;
  localparam int DIST_W     = 17;
  localparam int OUT_DIST_W = 16;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 5;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd1;

  // Input command codes.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_BLOCK = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNREACH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CMP, S_Q_CHK, S_INIT, S_SRC, S_SEL_RD, S_SEL_CMP,
    S_MOD, S_REL_RD, S_REL_EDGE, S_REL_NODE, S_WAIT, S_UPD, S_DONE
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_FIND_READ, OP_FIND_NEXT, OP_EDGE_APPEND, OP_EDGE_FULL,
    OP_MASK_CLEAR, OP_MASK_SET, OP_Q_BAD, OP_Q_START, OP_INIT_WRITE, OP_SRC_WRITE,
    OP_SEL_READ, OP_SEL_CMP, OP_SEL_NONE, OP_SETTLE, OP_MOD_STEP, OP_SEL_RESTART,
    OP_REL_READ, OP_REL_EDGE, OP_REL_SKIP, OP_REL_NODE, OP_WAIT_STEP, OP_WAIT_HIT,
    OP_UPDATE, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd_code;
    logic       find_end;
    logic       full;
    logic       ends_match;
    logic       q_bad;
    logic       init_last;
    logic       sel_end;
    logic       found;
    logic       u_is_dst;
    logic       mod_last;
    logic       rel_end;
    logic       edge_hit;
    logic       v_settled;
    logic       slot_free;
    logic       wait_last;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ===== src/periodic_block_shortest_path_core.sv =====
// Top level of the periodic block shortest path core: controller, datapath and checks.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_command, in_node_a, in_node_b, in_slot
//  out     | output    | out_valid / out_ready | out_status, out_distance
//  cfg     | input     | cfg_write_en          | cfg_index, cfg_data
//
// One transaction is worked at a time. An edge add or block scans the stored edges one
// by one. A query first clears the node memory, then per settled node runs a minimum
// scan over the nodes, a bitwise modulo of its distance by the period, and a pass over the
// stored edges that waits for a free period slot where an edge is blocked.
// Reset is synchronous and needs no clearing pass. A stalled result holds the core in
// its final state until the output register is free.
module periodic_block_shortest_path_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic [pbsp_pkg::NODE_W-1:0]         in_node_a,
  input  logic [pbsp_pkg::NODE_W-1:0]         in_node_b,
  input  logic [pbsp_pkg::SLOT_W-1:0]         in_slot,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [pbsp_pkg::OUT_DIST_W-1:0]     out_distance,
  input  logic                                cfg_write_en,
  input  logic [pbsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbsp_pkg::CFG_W-1:0]          cfg_data
);

  pbsp_pkg::ctrl_cmd_t cmd;
  pbsp_pkg::dp_stat_t  stat;

  pbsp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  pbsp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_command(in_command), .in_node_a(in_node_a),
    .in_node_b(in_node_b), .in_slot(in_slot), .out_valid(out_valid),
    .out_ready(out_ready), .out_status(out_status), .out_distance(out_distance),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat)
  );

  // An accepted transaction takes the core out of its idle state.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  // A new result appears only at the end of a transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a transaction in flight");

  // A result never carries an unused status code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("illegal result status");

  // The edge count never passes the table size.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && cmd.op == pbsp_pkg::OP_EDGE_APPEND))
    else $error("edge appended into a full table");

endmodule

// ===== src/pbsp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pbsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/pbsp_ctrl.sv =====
// Controller state machine that sequences edge loading and the query search.
module pbsp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pbsp_pkg::dp_stat_t   stat,
  output pbsp_pkg::ctrl_cmd_t  cmd
);

  pbsp_pkg::ctrl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbsp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbsp_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pbsp_pkg::S_FIND_RD;
        end
      end
      pbsp_pkg::S_FIND_RD: begin
        if (stat.cmd_code == pbsp_pkg::CMD_QUERY) begin
          state_nxt = pbsp_pkg::S_Q_CHK;
        end else if (stat.cmd_code != pbsp_pkg::CMD_ADD &&
                     stat.cmd_code != pbsp_pkg::CMD_BLOCK) begin
          state_nxt = pbsp_pkg::S_DONE;
        end else if (stat.find_end) begin
          state_nxt = pbsp_pkg::S_DONE;
        end else begin
          state_nxt = pbsp_pkg::S_FIND_CMP;
        end
      end
      pbsp_pkg::S_FIND_CMP: begin
        state_nxt = stat.ends_match ? pbsp_pkg::S_DONE : pbsp_pkg::S_FIND_RD;
      end
      pbsp_pkg::S_Q_CHK: begin
        state_nxt = stat.q_bad ? pbsp_pkg::S_DONE : pbsp_pkg::S_INIT;
      end
      pbsp_pkg::S_INIT: begin
        if (stat.init_last) begin
          state_nxt = pbsp_pkg::S_SRC;
        end
      end
      pbsp_pkg::S_SRC: begin
        state_nxt = pbsp_pkg::S_SEL_RD;
      end
      pbsp_pkg::S_SEL_RD: begin
        if (!stat.sel_end) begin
          state_nxt = pbsp_pkg::S_SEL_CMP;
        end else if (!stat.found || stat.u_is_dst) begin
          state_nxt = pbsp_pkg::S_DONE;
        end else begin
          state_nxt = pbsp_pkg::S_MOD;
        end
      end
      pbsp_pkg::S_SEL_CMP: begin
        state_nxt = pbsp_pkg::S_SEL_RD;
      end
      pbsp_pkg::S_MOD: begin
        if (stat.mod_last) begin
          state_nxt = pbsp_pkg::S_REL_RD;
        end
      end
      pbsp_pkg::S_REL_RD: begin
        state_nxt = stat.rel_end ? pbsp_pkg::S_SEL_RD : pbsp_pkg::S_REL_EDGE;
      end
      pbsp_pkg::S_REL_EDGE: begin
        state_nxt = stat.edge_hit ? pbsp_pkg::S_REL_NODE : pbsp_pkg::S_REL_RD;
      end
      pbsp_pkg::S_REL_NODE: begin
        state_nxt = stat.v_settled ? pbsp_pkg::S_REL_RD : pbsp_pkg::S_WAIT;
      end
      pbsp_pkg::S_WAIT: begin
        if (stat.slot_free) begin
          state_nxt = pbsp_pkg::S_UPD;
        end else if (stat.wait_last) begin
          state_nxt = pbsp_pkg::S_REL_RD;
        end
      end
      pbsp_pkg::S_UPD: begin
        state_nxt = pbsp_pkg::S_REL_RD;
      end
      pbsp_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = pbsp_pkg::S_IDLE;
        end
      end
      default: state_nxt = pbsp_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshake and datapath command.
  always_comb begin
    in_ready = (state_r == pbsp_pkg::S_IDLE);
    cmd.op   = pbsp_pkg::OP_NONE;
    unique case (state_r)
      pbsp_pkg::S_IDLE: begin
        if (in_valid) cmd.op = pbsp_pkg::OP_ACCEPT;
      end
      pbsp_pkg::S_FIND_RD: begin
        if (stat.cmd_code == pbsp_pkg::CMD_ADD || stat.cmd_code == pbsp_pkg::CMD_BLOCK) begin
          if (!stat.find_end) begin
            cmd.op = pbsp_pkg::OP_FIND_READ;
          end else if (stat.cmd_code == pbsp_pkg::CMD_ADD) begin
            cmd.op = stat.full ? pbsp_pkg::OP_EDGE_FULL : pbsp_pkg::OP_EDGE_APPEND;
          end
        end
      end
      pbsp_pkg::S_FIND_CMP: begin
        if (!stat.ends_match) begin
          cmd.op = pbsp_pkg::OP_FIND_NEXT;
        end else if (stat.cmd_code == pbsp_pkg::CMD_ADD) begin
          cmd.op = pbsp_pkg::OP_MASK_CLEAR;
        end else begin
          cmd.op = pbsp_pkg::OP_MASK_SET;
        end
      end
      pbsp_pkg::S_Q_CHK: begin
        cmd.op = stat.q_bad ? pbsp_pkg::OP_Q_BAD : pbsp_pkg::OP_Q_START;
      end
      pbsp_pkg::S_INIT:    cmd.op = pbsp_pkg::OP_INIT_WRITE;
      pbsp_pkg::S_SRC:     cmd.op = pbsp_pkg::OP_SRC_WRITE;
      pbsp_pkg::S_SEL_RD: begin
        if (!stat.sel_end) begin
          cmd.op = pbsp_pkg::OP_SEL_READ;
        end else begin
          cmd.op = stat.found ? pbsp_pkg::OP_SETTLE : pbsp_pkg::OP_SEL_NONE;
        end
      end
      pbsp_pkg::S_SEL_CMP: cmd.op = pbsp_pkg::OP_SEL_CMP;
      pbsp_pkg::S_MOD:     cmd.op = pbsp_pkg::OP_MOD_STEP;
      pbsp_pkg::S_REL_RD: begin
        cmd.op = stat.rel_end ? pbsp_pkg::OP_SEL_RESTART : pbsp_pkg::OP_REL_READ;
      end
      pbsp_pkg::S_REL_EDGE: begin
        cmd.op = stat.edge_hit ? pbsp_pkg::OP_REL_EDGE : pbsp_pkg::OP_REL_SKIP;
      end
      pbsp_pkg::S_REL_NODE: begin
        cmd.op = stat.v_settled ? pbsp_pkg::OP_REL_SKIP : pbsp_pkg::OP_REL_NODE;
      end
      pbsp_pkg::S_WAIT: begin
        if (stat.slot_free) begin
          cmd.op = pbsp_pkg::OP_WAIT_HIT;
        end else if (stat.wait_last) begin
          cmd.op = pbsp_pkg::OP_REL_SKIP;
        end else begin
          cmd.op = pbsp_pkg::OP_WAIT_STEP;
        end
      end
      pbsp_pkg::S_UPD:     cmd.op = pbsp_pkg::OP_UPDATE;
      pbsp_pkg::S_DONE: begin
        if (!stat.out_busy) cmd.op = pbsp_pkg::OP_EMIT;
      end
      default: cmd.op = pbsp_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== src/pbsp_dp.sv =====
// Datapath: edge and node memories, counters, modulo and wait units, result register.
module pbsp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [1:0]                           in_command,
  input  logic [pbsp_pkg::NODE_W-1:0]          in_node_a,
  input  logic [pbsp_pkg::NODE_W-1:0]          in_node_b,
  input  logic [pbsp_pkg::SLOT_W-1:0]          in_slot,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [pbsp_pkg::OUT_DIST_W-1:0]      out_distance,
  input  logic                                 cfg_write_en,
  input  logic [pbsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbsp_pkg::CFG_W-1:0]           cfg_data,
  input  pbsp_pkg::ctrl_cmd_t                  cmd,
  output pbsp_pkg::dp_stat_t                   stat
);

  localparam int NW = pbsp_pkg::NODE_W;
  localparam int DW = pbsp_pkg::DIST_W;

  // Configuration registers.
  logic [pbsp_pkg::NODE_CNT_W-1:0] node_count_r;
  logic [pbsp_pkg::PER_W-1:0]      period_r;

  // Transaction fields and search state.
  logic [1:0]                         cmd_r;
  logic [NW-1:0]                      lo_r, hi_r, a_r, b_r, u_r, v_r;
  logic [pbsp_pkg::SLOT_W-1:0]        slot_r, s_r, w_r;
  logic [pbsp_pkg::EDGE_CNT_W-1:0]    idx_r, total_r;
  logic [DW-1:0]                      best_r, old_r, nd_r;
  logic                               found_r;
  logic [pbsp_pkg::PER_W-1:0]         rem_r;
  logic [pbsp_pkg::CNT_W-1:0]         cnt_r;
  logic [1:0]                         res_status_r;
  logic [pbsp_pkg::OUT_DIST_W-1:0]    res_dist_r;
  logic                               out_valid_r;
  logic [1:0]                         out_status_r;
  logic [pbsp_pkg::OUT_DIST_W-1:0]    out_dist_r;

  // Memory ports.
  logic                              ends_we, mask_we, edge_re, node_we, node_re;
  logic [pbsp_pkg::EDGE_AW-1:0]      edge_waddr;
  logic [2*NW-1:0]                   ends_q;
  logic [pbsp_pkg::MASK_W-1:0]       mask_wdata, mask_q;
  logic [NW-1:0]                     node_waddr, node_raddr;
  logic [DW:0]                       node_wdata, node_q;

  // Derived values.
  logic [pbsp_pkg::NODE_CNT_W-1:0]   eff_n;
  logic [pbsp_pkg::EDGE_CNT_W-1:0]   eff_n_ext;
  logic [pbsp_pkg::PER_W-1:0]        eff_len;
  logic [NW-1:0]                     e_lo, e_hi, v_c;
  logic                              incident;
  logic [pbsp_pkg::PER_W:0]          mod_t;
  logic [pbsp_pkg::OUT_DIST_W-1:0]   best_clamp;

  // Effective register values with out of range codes folded in.
  always_comb begin
    if (node_count_r == '0) begin
      eff_n = pbsp_pkg::NODE_CNT_W'(1);
    end else if (node_count_r > pbsp_pkg::NODE_CNT_W'(pbsp_pkg::MAX_NODES)) begin
      eff_n = pbsp_pkg::NODE_CNT_W'(pbsp_pkg::MAX_NODES);
    end else begin
      eff_n = node_count_r;
    end
    if (period_r == '0) begin
      eff_len = pbsp_pkg::PER_W'(1);
    end else if (period_r > pbsp_pkg::PER_W'(pbsp_pkg::MAX_PERIOD)) begin
      eff_len = pbsp_pkg::PER_W'(pbsp_pkg::MAX_PERIOD);
    end else begin
      eff_len = period_r;
    end
  end

  assign eff_n_ext = pbsp_pkg::EDGE_CNT_W'(eff_n);
  assign e_lo      = ends_q[2*NW-1:NW];
  assign e_hi      = ends_q[NW-1:0];
  assign incident  = (e_lo == u_r) || (e_hi == u_r);
  assign v_c       = (e_lo == u_r) ? e_hi : e_lo;
  assign mod_t     = {rem_r, best_r[cnt_r]};
  assign best_clamp = (best_r > DW'(16'hFFFF)) ? 16'hFFFF
                                               : best_r[pbsp_pkg::OUT_DIST_W-1:0];

  // Status toward the controller.
  always_comb begin
    stat.cmd_code   = cmd_r;
    stat.find_end   = (idx_r == total_r);
    stat.full       = (total_r == pbsp_pkg::EDGE_CNT_W'(pbsp_pkg::MAX_EDGES));
    stat.ends_match = (ends_q == {lo_r, hi_r});
    stat.q_bad      = (pbsp_pkg::NODE_CNT_W'(a_r) >= eff_n) ||
                      (pbsp_pkg::NODE_CNT_W'(b_r) >= eff_n);
    stat.init_last  = (idx_r == eff_n_ext - pbsp_pkg::EDGE_CNT_W'(1));
    stat.sel_end    = (idx_r == eff_n_ext);
    stat.found      = found_r;
    stat.u_is_dst   = (u_r == b_r);
    stat.mod_last   = (cnt_r == '0);
    stat.rel_end    = (idx_r == total_r);
    stat.edge_hit   = incident && (pbsp_pkg::NODE_CNT_W'(v_c) < eff_n);
    stat.v_settled  = node_q[DW];
    stat.slot_free  = !mask_q[s_r];
    stat.wait_last  = (pbsp_pkg::PER_W'(w_r) == eff_len - pbsp_pkg::PER_W'(1));
    stat.out_busy   = out_valid_r && !out_ready;
  end

  // Memory port control.
  always_comb begin
    ends_we    = (cmd.op == pbsp_pkg::OP_EDGE_APPEND);
    mask_we    = (cmd.op == pbsp_pkg::OP_EDGE_APPEND) || (cmd.op == pbsp_pkg::OP_MASK_CLEAR) ||
                 (cmd.op == pbsp_pkg::OP_MASK_SET);
    edge_waddr = (cmd.op == pbsp_pkg::OP_EDGE_APPEND) ? total_r[pbsp_pkg::EDGE_AW-1:0]
                                                      : idx_r[pbsp_pkg::EDGE_AW-1:0];
    mask_wdata = (cmd.op == pbsp_pkg::OP_MASK_SET)
                 ? (mask_q | (pbsp_pkg::MASK_W'(1) << slot_r)) : '0;
    edge_re    = (cmd.op == pbsp_pkg::OP_FIND_READ) || (cmd.op == pbsp_pkg::OP_REL_READ);
    node_re    = (cmd.op == pbsp_pkg::OP_SEL_READ) || (cmd.op == pbsp_pkg::OP_REL_EDGE);
    node_raddr = (cmd.op == pbsp_pkg::OP_REL_EDGE) ? v_c : idx_r[NW-1:0];
    node_we    = 1'b0;
    node_waddr = idx_r[NW-1:0];
    node_wdata = {1'b0, pbsp_pkg::DIST_INF};
    priority case (cmd.op)
      pbsp_pkg::OP_INIT_WRITE: node_we = 1'b1;
      pbsp_pkg::OP_SRC_WRITE: begin
        node_we    = 1'b1;
        node_waddr = a_r;
        node_wdata = '0;
      end
      pbsp_pkg::OP_SETTLE: begin
        node_we    = 1'b1;
        node_waddr = u_r;
        node_wdata = {1'b1, best_r};
      end
      pbsp_pkg::OP_UPDATE: begin
        node_we    = (nd_r < old_r);
        node_waddr = v_r;
        node_wdata = {1'b0, nd_r};
      end
      default: node_we = 1'b0;
    endcase
  end

  pbsp_ram #(.WIDTH(2*NW), .DEPTH(pbsp_pkg::MAX_EDGES)) u_ends_ram (
    .clk(clk), .wr_en(ends_we), .wr_addr(edge_waddr), .wr_data({lo_r, hi_r}),
    .rd_en(edge_re), .rd_addr(idx_r[pbsp_pkg::EDGE_AW-1:0]), .rd_data(ends_q)
  );

  pbsp_ram #(.WIDTH(pbsp_pkg::MASK_W), .DEPTH(pbsp_pkg::MAX_EDGES)) u_mask_ram (
    .clk(clk), .wr_en(mask_we), .wr_addr(edge_waddr), .wr_data(mask_wdata),
    .rd_en(edge_re), .rd_addr(idx_r[pbsp_pkg::EDGE_AW-1:0]), .rd_data(mask_q)
  );

  pbsp_ram #(.WIDTH(DW+1), .DEPTH(pbsp_pkg::MAX_NODES)) u_node_ram (
    .clk(clk), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
    .rd_en(node_re), .rd_addr(node_raddr), .rd_data(node_q)
  );

  // Control registers: configuration, edge count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= pbsp_pkg::NODE_CNT_W'(pbsp_pkg::MAX_NODES);
      period_r     <= pbsp_pkg::PER_W'(1);
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_write_en && cfg_index == pbsp_pkg::CFG_NODE_COUNT) begin
        node_count_r <= cfg_data;
      end
      if (cfg_write_en && cfg_index == pbsp_pkg::CFG_PERIOD) begin
        period_r <= cfg_data[pbsp_pkg::PER_W-1:0];
      end
      if (cmd.op == pbsp_pkg::OP_EDGE_APPEND) begin
        total_r <= total_r + pbsp_pkg::EDGE_CNT_W'(1);
      end
      if (cmd.op == pbsp_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers of the transaction and the search.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pbsp_pkg::OP_ACCEPT: begin
        cmd_r        <= in_command;
        a_r          <= in_node_a;
        b_r          <= in_node_b;
        lo_r         <= (in_node_a < in_node_b) ? in_node_a : in_node_b;
        hi_r         <= (in_node_a < in_node_b) ? in_node_b : in_node_a;
        slot_r       <= in_slot;
        idx_r        <= '0;
        res_status_r <= pbsp_pkg::ST_OK;
        res_dist_r   <= '0;
      end
      pbsp_pkg::OP_FIND_NEXT, pbsp_pkg::OP_INIT_WRITE, pbsp_pkg::OP_REL_SKIP,
      pbsp_pkg::OP_UPDATE: begin
        idx_r <= idx_r + pbsp_pkg::EDGE_CNT_W'(1);
      end
      pbsp_pkg::OP_EDGE_FULL: res_status_r <= pbsp_pkg::ST_FULL;
      pbsp_pkg::OP_Q_BAD, pbsp_pkg::OP_SEL_NONE: res_status_r <= pbsp_pkg::ST_UNREACH;
      pbsp_pkg::OP_Q_START: idx_r <= '0;
      pbsp_pkg::OP_SRC_WRITE, pbsp_pkg::OP_SEL_RESTART: begin
        idx_r   <= '0;
        found_r <= 1'b0;
        best_r  <= pbsp_pkg::DIST_INF;
      end
      pbsp_pkg::OP_SEL_CMP: begin
        if (!node_q[DW] && node_q[DW-1:0] < best_r) begin
          best_r  <= node_q[DW-1:0];
          u_r     <= idx_r[NW-1:0];
          found_r <= 1'b1;
        end
        idx_r <= idx_r + pbsp_pkg::EDGE_CNT_W'(1);
      end
      pbsp_pkg::OP_SETTLE: begin
        if (u_r == b_r) begin
          res_dist_r <= best_clamp;
        end
        cnt_r <= pbsp_pkg::CNT_W'(DW - 1);
        rem_r <= '0;
        idx_r <= '0;
      end
      // One bit of the restoring remainder of the settled distance by the period.
      pbsp_pkg::OP_MOD_STEP: begin
        if (mod_t >= {1'b0, eff_len}) begin
          rem_r <= pbsp_pkg::PER_W'(mod_t - {1'b0, eff_len});
        end else begin
          rem_r <= mod_t[pbsp_pkg::PER_W-1:0];
        end
        cnt_r <= cnt_r - pbsp_pkg::CNT_W'(1);
      end
      pbsp_pkg::OP_REL_EDGE: v_r <= v_c;
      pbsp_pkg::OP_REL_NODE: begin
        old_r <= node_q[DW-1:0];
        s_r   <= rem_r[pbsp_pkg::SLOT_W-1:0];
        w_r   <= '0;
      end
      // Walk the slot ring one slot per cycle until a free one is found or the whole period is tried.
      pbsp_pkg::OP_WAIT_STEP: begin
        w_r <= w_r + pbsp_pkg::SLOT_W'(1);
        if (pbsp_pkg::PER_W'(s_r) == eff_len - pbsp_pkg::PER_W'(1)) begin
          s_r <= '0;
        end else begin
          s_r <= s_r + pbsp_pkg::SLOT_W'(1);
        end
      end
      pbsp_pkg::OP_WAIT_HIT: nd_r <= best_r + DW'(w_r) + DW'(1);
      pbsp_pkg::OP_EMIT: begin
        out_status_r <= res_status_r;
        out_dist_r   <= res_dist_r;
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_distance = out_dist_r;

endmodule
